[sv/bounded_ordered_list_engine_unit_macros.svh]
`ifndef BOUNDED_ORDERED_LIST_ENGINE_UNIT_MACROS_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define BOLE_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define BOLE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/bole_pkg.sv]
`timescale 1ns / 1ps

package bole_pkg;

    // Command codes
    localparam logic [2:0] CMD_INS_FRONT = 3'd0;
    localparam logic [2:0] CMD_INS_BACK  = 3'd1;
    localparam logic [2:0] CMD_SEARCH    = 3'd2;
    localparam logic [2:0] CMD_REMOVE    = 3'd3;
    localparam logic [2:0] CMD_CLEAR     = 3'd4;

    // Result status codes
    localparam logic [1:0] STAT_DONE      = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] value;
    } bole_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] match_position;
        logic [4:0] length;
    } bole_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT_DN,
        ST_SHIFT_UP,
        ST_RESULT
    } bole_state_t;

endpackage

[sv/bole_mem.sv]
`timescale 1ns / 1ps

module bole_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_data
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/bole_ctrl.sv]
`timescale 1ns / 1ps

module bole_ctrl import bole_pkg::*; #(
    parameter int CAPACITY = 16,
    parameter int IDX_W    = 4,
    parameter int CNT_W    = 5
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  bole_in_t         s_item,
    output logic             res_valid,
    input  logic             res_ready,
    output bole_out_t        res_item,
    output logic [CNT_W-1:0] count,
    output logic             mem_wr_en,
    output logic [IDX_W-1:0] mem_wr_addr,
    output logic [31:0]      mem_wr_data,
    output logic             mem_rd_en,
    output logic [IDX_W-1:0] mem_rd_addr,
    input  logic [31:0]      mem_rd_data
);

    bole_state_t      state_reg, state_next;
    logic [2:0]       cmd_reg, cmd_next;
    logic [31:0]      val_reg, val_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic             chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [1:0]       status_reg, status_next;

    logic             full;
    logic             hit;
    logic [IDX_W+3:0] pos_wide;
    logic [CNT_W+4:0] len_wide;

    assign full = (count_reg == CNT_W'(CAPACITY));
    // Shared equality compare against the entry fetched last cycle
    assign hit  = chk_valid_reg && (mem_rd_data == val_reg);

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            chk_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            chk_valid_reg <= chk_valid_next;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        val_reg     <= val_next;
        ptr_reg     <= ptr_next;
        chk_idx_reg <= chk_idx_next;
        pos_reg     <= pos_next;
        status_reg  <= status_next;
    end

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        val_next       = val_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        chk_valid_next = chk_valid_reg;
        chk_idx_next   = chk_idx_reg;
        pos_next       = pos_reg;
        status_next    = status_reg;
        s_ready        = 1'b0;
        res_valid      = 1'b0;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = '0;
        mem_wr_data    = val_reg;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = '0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_next       = s_item.cmd;
                    val_next       = s_item.value;
                    pos_next       = '0;
                    status_next    = STAT_DONE;
                    chk_valid_next = 1'b0;
                    ptr_next       = '0;
                    state_next     = ST_RESULT;
                    case (s_item.cmd)
                        CMD_INS_FRONT: begin
                            if (full) begin
                                status_next = STAT_FULL;
                            end else begin
                                ptr_next   = count_reg;
                                state_next = ST_SHIFT_UP;
                            end
                        end
                        CMD_INS_BACK: begin
                            if (full) begin
                                status_next = STAT_FULL;
                            end else begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = count_reg[IDX_W-1:0];
                                mem_wr_data = s_item.value;
                                count_next  = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_SEARCH, CMD_REMOVE: begin
                            state_next = ST_SCAN;
                        end
                        CMD_CLEAR: begin
                            count_next = '0;
                        end
                        default: begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                // Walk from the front, one read per cycle, compare each entry in the next cycle
                if (hit) begin
                    pos_next       = chk_idx_reg;
                    chk_valid_next = 1'b0;
                    if (cmd_reg == CMD_REMOVE) begin
                        ptr_next   = CNT_W'(chk_idx_reg) + CNT_W'(1);
                        state_next = ST_SHIFT_DN;
                    end else begin
                        state_next = ST_RESULT;
                    end
                end else if (ptr_reg < count_reg) begin
                    mem_rd_en      = 1'b1;
                    mem_rd_addr    = ptr_reg[IDX_W-1:0];
                    chk_valid_next = 1'b1;
                    chk_idx_next   = ptr_reg[IDX_W-1:0];
                    ptr_next       = ptr_reg + CNT_W'(1);
                end else begin
                    chk_valid_next = 1'b0;
                    status_next    = STAT_NOT_FOUND;
                    state_next     = ST_RESULT;
                end
            end

            ST_SHIFT_DN: begin
                // Close the gap: entry j moves to j-1
                if (chk_valid_reg) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = chk_idx_reg - IDX_W'(1);
                    mem_wr_data = mem_rd_data;
                end
                if (ptr_reg < count_reg) begin
                    mem_rd_en      = 1'b1;
                    mem_rd_addr    = ptr_reg[IDX_W-1:0];
                    chk_valid_next = 1'b1;
                    chk_idx_next   = ptr_reg[IDX_W-1:0];
                    ptr_next       = ptr_reg + CNT_W'(1);
                end else begin
                    chk_valid_next = 1'b0;
                    if (!chk_valid_reg) begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = ST_RESULT;
                    end
                end
            end

            ST_SHIFT_UP: begin
                // Open a slot at the front: entry j moves to j+1, back to front
                if (chk_valid_reg) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = chk_idx_reg + IDX_W'(1);
                    mem_wr_data = mem_rd_data;
                end
                if (ptr_reg != '0) begin
                    mem_rd_en      = 1'b1;
                    mem_rd_addr    = ptr_reg[IDX_W-1:0] - IDX_W'(1);
                    chk_valid_next = 1'b1;
                    chk_idx_next   = ptr_reg[IDX_W-1:0] - IDX_W'(1);
                    ptr_next       = ptr_reg - CNT_W'(1);
                end else begin
                    chk_valid_next = 1'b0;
                    if (!chk_valid_reg) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = '0;
                        mem_wr_data = val_reg;
                        count_next  = count_reg + CNT_W'(1);
                        state_next  = ST_RESULT;
                    end
                end
            end

            ST_RESULT: begin
                // Hold the result until the output stage takes it
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Mask position and length to the result field widths
    assign pos_wide = {4'b0, pos_reg};
    assign len_wide = {5'b0, count_reg};

    assign res_item.status         = status_reg;
    assign res_item.match_position = pos_wide[3:0];
    assign res_item.length         = len_wide[4:0];
    assign count                   = count_reg;

endmodule

[sv/bounded_ordered_list_engine_unit.sv]
`timescale 1ns / 1ps
`include "bounded_ordered_list_engine_unit_macros.svh"

// Ordered list of up to CAPACITY signed 32-bit values held in a RAM with one registered
// read port, driven by one command per input beat (insert front, insert back, search,
// remove first match, clear) and returning exactly one result beat per command. The block
// takes one command at a time and is not ready while it works. Insert back, clear, a
// rejected insert and unused codes go straight to the result. Search fetches the entries
// one per cycle through the read port and compares each in the next cycle against the search
// value. Remove, after the match, moves each later entry down one slot, then writes the
// last moved entry and updates the length. Insert front moves every entry up one slot
// from the back through the same read port before writing the new front. The next
// command can be accepted in the cycle after the result is loaded into the output register.
// A finished result sits in the output register, so the next command runs while it waits
// to be taken; a second result holds the block until the first is taken.
// RAM contents need no clearing after reset; only slots below the length are read.
module bounded_ordered_list_engine_unit import bole_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  bole_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output bole_out_t m_data
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic             res_valid;
    logic             res_ready;
    bole_out_t        res_item;
    logic [CNT_W-1:0] count;
    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    logic [31:0]      mem_wr_data;
    logic             mem_rd_en;
    logic [IDX_W-1:0] mem_rd_addr;
    logic [31:0]      mem_rd_data;

    logic             m_valid_reg, m_valid_next;
    bole_out_t        m_data_reg, m_data_next;

    bole_ctrl #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_item    (res_item),
        .count       (count),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    bole_mem #(
        .DEPTH (CAPACITY),
        .AW    (IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Output register: load when empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_data_next  = res_item;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Checks
    `BOLE_ASSERT_SAME(a_count_bound, aclk, aresetn, 1'b1, count <= CNT_W'(CAPACITY), "length over cap")
    `BOLE_ASSERT_SAME(a_one_at_a_time, aclk, aresetn, s_ready, !res_valid, "accept with result pending")
    `BOLE_ASSERT_NEXT(a_result_loads, aclk, aresetn, res_valid && res_ready, m_valid, "result not loaded")

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import bole_pkg::*;

    localparam int CAPACITY = 16;
    localparam int CLK_PERIOD = 20;
    localparam int SETTLE_CYCLES = 3 * CAPACITY + 8;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int RUN_LIMIT_NS = 10_000_000;
    // Command codes the block leaves unused
    localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] CMD_LAST_UNUSED  = 3'd7;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    bole_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    bole_out_t m_data;

    bole_in_t           cmd_backlog[$];
    bole_out_t          list_replies_due[$];
    logic signed [31:0] shadow_list[$];
    logic signed [31:0] value_pool[6];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    bit failed = 1'b0;

    bounded_ordered_list_engine_unit #(
        .CAPACITY(CAPACITY)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Apply one command to the shadow list and return the reply it should produce
    function automatic bole_out_t apply_list_cmd(bole_in_t item);
        bole_out_t reply;
        int hit;
        int i;
        reply.status = STAT_DONE;
        reply.match_position = '0;
        hit = -1;
        case (item.cmd)
            CMD_INS_FRONT: begin
                if (shadow_list.size() >= CAPACITY) reply.status = STAT_FULL;
                else shadow_list.push_front(item.value);
            end
            CMD_INS_BACK: begin
                if (shadow_list.size() >= CAPACITY) reply.status = STAT_FULL;
                else shadow_list.push_back(item.value);
            end
            CMD_SEARCH, CMD_REMOVE: begin
                for (i = 0; i < shadow_list.size() && hit < 0; i++) begin
                    if (shadow_list[i] === item.value) hit = i;
                end
                if (hit < 0) begin
                    reply.status = STAT_NOT_FOUND;
                end else begin
                    reply.match_position = hit[3:0];
                    if (item.cmd == CMD_REMOVE) shadow_list.delete(hit);
                end
            end
            CMD_CLEAR: shadow_list.delete();
            default: ;
        endcase
        reply.length = 5'(shadow_list.size());
        return reply;
    endfunction

    // Sender: hold a beat until taken, then offer the next one or idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) list_replies_due.push_back(apply_list_cmd(s_data));
            if (s_valid && !s_ready) begin
                s_valid <= 1'b1;
            end else if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data <= cmd_backlog.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver ready: long hold-off when requested, else random stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each result beat with the oldest reply due
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (list_replies_due.size() == 0) begin
                $display("%0t: unexpected result beat %p", $time, m_data);
                failed = 1'b1;
            end else begin
                bole_out_t want;
                want = list_replies_due.pop_front();
                if (m_data.status !== want.status) begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, want.status, m_data.status);
                    failed = 1'b1;
                end
                if (m_data.match_position !== want.match_position) begin
                    $display("%0t: match_position expected %0d, got %0d",
                             $time, want.match_position, m_data.match_position);
                    failed = 1'b1;
                end
                if (m_data.length !== want.length) begin
                    $display("%0t: length expected %0d, got %0d",
                             $time, want.length, m_data.length);
                    failed = 1'b1;
                end
            end
        end
    end

    task automatic push_cmd(logic [2:0] cmd, logic signed [31:0] value);
        bole_in_t item;
        item.cmd = cmd;
        item.value = value;
        cmd_backlog.push_back(item);
    endtask

    // Block until every queued command has gone out and every reply has come back
    task automatic wait_drained();
        while (cmd_backlog.size() != 0 || s_valid || list_replies_due.size() != 0)
            @(negedge aclk);
    endtask

    // Random commands, values mostly drawn from a small pool so matches happen
    task automatic queue_random(int count);
        int pick;
        logic [2:0] cmd;
        logic signed [31:0] value;
        foreach (value_pool[k]) value_pool[k] = $urandom();
        value_pool[0] = $urandom_range(3);
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 25) cmd = CMD_INS_FRONT;
            else if (pick < 45) cmd = CMD_INS_BACK;
            else if (pick < 66) cmd = CMD_SEARCH;
            else if (pick < 90) cmd = CMD_REMOVE;
            else if (pick < 92) cmd = CMD_CLEAR;
            else cmd = 3'($urandom_range(CMD_LAST_UNUSED, CMD_FIRST_UNUSED));
            pick = $urandom_range(99);
            if (pick < 60) value = value_pool[$urandom_range(5)];
            else if (pick < 66) value = VAL_MIN;
            else if (pick < 72) value = VAL_MAX;
            else if (pick < 78) value = -1;
            else value = $urandom();
            push_cmd(cmd, value);
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty list, extremes, duplicates, first match, unused codes
        push_cmd(CMD_CLEAR, 0);
        push_cmd(CMD_SEARCH, 0);
        push_cmd(CMD_REMOVE, VAL_MIN);
        push_cmd(CMD_INS_FRONT, VAL_MIN);
        push_cmd(CMD_INS_BACK, VAL_MAX);
        push_cmd(CMD_INS_FRONT, -1);
        push_cmd(CMD_INS_BACK, 0);
        push_cmd(CMD_INS_BACK, -1);
        push_cmd(CMD_SEARCH, -1);
        push_cmd(CMD_SEARCH, VAL_MAX);
        push_cmd(CMD_SEARCH, 32'sh7fff_fffe);
        push_cmd(CMD_REMOVE, -1);
        push_cmd(CMD_SEARCH, -1);
        push_cmd(CMD_REMOVE, VAL_MAX);
        for (int c = CMD_FIRST_UNUSED; c <= CMD_LAST_UNUSED; c++) push_cmd(3'(c), VAL_MAX);
        push_cmd(CMD_REMOVE, 0);
        push_cmd(CMD_CLEAR, -1);
        push_cmd(CMD_SEARCH, VAL_MIN);
        wait_drained();

        // No idling
        queue_random(125);
        wait_drained();

        // Sender idles often
        send_idle_pct = 63;
        queue_random(125);
        wait_drained();

        // Receiver stalls often
        send_idle_pct = 0;
        recv_stall_pct = 63;
        queue_random(125);
        wait_drained();

        // Both sides idle
        send_idle_pct = 26;
        recv_stall_pct = 26;
        queue_random(125);
        wait_drained();

        // Receiver holds off at the start; the sender sends more inserts than the list can hold
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = HOLD_OFF_CYCLES;
        push_cmd(CMD_CLEAR, 0);
        for (int n = 0; n < CAPACITY + 4; n++)
            push_cmd($urandom_range(1) ? CMD_INS_BACK : CMD_INS_FRONT, $urandom());
        push_cmd(CMD_SEARCH, 0);
        push_cmd(CMD_REMOVE, VAL_MIN);
        wait_drained();

        // Random traffic again from a full list
        recv_stall_pct = 26;
        queue_random(120);
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (list_replies_due.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, list_replies_due.size());
            failed = 1'b1;
        end
        if (!failed) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #(RUN_LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/bole_pkg.sv
sv/bole_mem.sv
sv/bole_ctrl.sv
sv/bounded_ordered_list_engine_unit.sv
tb/sv/tb_top.sv
